// ===== rtl/rect_triangle_overlap_macros.svh =====
// Assertion macros shared by the rectangle / triangle overlap block.
// Every macro samples on clk and is disabled while rst is high.
`ifndef RECT_TRIANGLE_OVERLAP_MACROS_SVH
`define RECT_TRIANGLE_OVERLAP_MACROS_SVH

// Same-cycle implication.
`define RTO_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication.
`define RTO_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/rto_pkg.sv =====
// ----------------------------------------------------------------------------
// rto_pkg
// Widths, result codes and stage types of the rectangle / triangle overlap test.
// ----------------------------------------------------------------------------
package rto_pkg;

  localparam int CoordBits = 16;
  localparam int HalfBits  = CoordBits - 1;
  // rectangle edges and triangle edge vectors
  localparam int EdgeBits  = CoordBits + 1;
  // rectangle corner minus triangle corner
  localparam int DiffBits  = CoordBits + 2;
  localparam int ProdBits  = EdgeBits + DiffBits;
  localparam int CrossBits = ProdBits + 1;

  localparam int InRawBits   = 8 * CoordBits + 2 * HalfBits;
  localparam int InDataBits  = ((InRawBits + 7) / 8) * 8;
  localparam int OutRawBits  = 3;
  localparam int OutDataBits = 8;

  localparam logic [1:0] DecReject    = 2'd0;
  localparam logic [1:0] DecTriInRect = 2'd1;
  localparam logic [1:0] DecRectInTri = 2'd2;
  localparam logic [1:0] DecNone      = 2'd3;

  // last field in the lowest bits
  typedef struct packed {
    logic signed [CoordBits-1:0] tri_cy;
    logic signed [CoordBits-1:0] tri_cx;
    logic signed [CoordBits-1:0] tri_by;
    logic signed [CoordBits-1:0] tri_bx;
    logic signed [CoordBits-1:0] tri_ay;
    logic signed [CoordBits-1:0] tri_ax;
    logic        [HalfBits-1:0]  rect_half_h;
    logic        [HalfBits-1:0]  rect_half_w;
    logic signed [CoordBits-1:0] rect_cy;
    logic signed [CoordBits-1:0] rect_cx;
  } in_item_t;

  // products of the edge tests: [rect corner][triangle edge]
  typedef struct packed {
    logic                             reject;
    logic                             tri_in;
    logic [3:0][2:0][ProdBits-1:0]    pa;
    logic [3:0][2:0][ProdBits-1:0]    pb;
  } mid_t;

  function automatic logic signed [EdgeBits-1:0] ext_e(input logic signed [CoordBits-1:0] v);
    return EdgeBits'(v);
  endfunction

endpackage

// ===== rtl/rto_setup.sv =====
// ----------------------------------------------------------------------------
// rto_setup
// Rectangle bounds, bounding-box reject, corner-in-rectangle test and the
// edge-test products for all four rectangle corners.
// ----------------------------------------------------------------------------
module rto_setup (
  input  rto_pkg::in_item_t item,
  output rto_pkg::mid_t     mid
);
  import rto_pkg::*;

  logic signed [EdgeBits-1:0]  left, right, low, high;
  logic signed [CoordBits-1:0] tx [3];
  logic signed [CoordBits-1:0] ty [3];
  logic signed [CoordBits-1:0] tminx, tmaxx, tminy, tmaxy;
  logic signed [EdgeBits-1:0]  qx [4];
  logic signed [EdgeBits-1:0]  qy [4];
  logic signed [EdgeBits-1:0]  ex [3];
  logic signed [EdgeBits-1:0]  ey [3];
  logic signed [DiffBits-1:0]  dx [4][3];
  logic signed [DiffBits-1:0]  dy [4][3];
  logic signed [ProdBits-1:0]  pa [4][3];
  logic signed [ProdBits-1:0]  pb [4][3];
  logic [2:0]                  corner_in;

  assign tx[0] = item.tri_ax;
  assign ty[0] = item.tri_ay;
  assign tx[1] = item.tri_bx;
  assign ty[1] = item.tri_by;
  assign tx[2] = item.tri_cx;
  assign ty[2] = item.tri_cy;

  assign left  = ext_e(item.rect_cx) - $signed({2'b00, item.rect_half_w});
  assign right = ext_e(item.rect_cx) + $signed({2'b00, item.rect_half_w});
  assign low   = ext_e(item.rect_cy) - $signed({2'b00, item.rect_half_h});
  assign high  = ext_e(item.rect_cy) + $signed({2'b00, item.rect_half_h});

  always_comb begin
    tminx = tx[0];
    tmaxx = tx[0];
    tminy = ty[0];
    tmaxy = ty[0];
    for (int i = 1; i < 3; i++) begin
      if (tx[i] < tminx) tminx = tx[i];
      if (tx[i] > tmaxx) tmaxx = tx[i];
      if (ty[i] < tminy) tminy = ty[i];
      if (ty[i] > tmaxy) tmaxy = ty[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      corner_in[i] = (left <= ext_e(tx[i])) && (right >= ext_e(tx[i])) &&
                     (low <= ext_e(ty[i])) && (high >= ext_e(ty[i]));
    end
  end

  assign qx[0] = left;
  assign qy[0] = low;
  assign qx[1] = left;
  assign qy[1] = high;
  assign qx[2] = right;
  assign qy[2] = low;
  assign qx[3] = right;
  assign qy[3] = high;

  // edge i runs from corner i to corner i+1 mod 3
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex[i] = ext_e(tx[(i + 1) % 3]) - ext_e(tx[i]);
      ey[i] = ext_e(ty[(i + 1) % 3]) - ext_e(ty[i]);
    end
  end

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      for (int i = 0; i < 3; i++) begin
        dx[q][i] = DiffBits'(qx[q]) - DiffBits'(tx[i]);
        dy[q][i] = DiffBits'(qy[q]) - DiffBits'(ty[i]);
        pa[q][i] = ProdBits'(ex[i]) * ProdBits'(dy[q][i]);
        pb[q][i] = ProdBits'(ey[i]) * ProdBits'(dx[q][i]);
      end
    end
  end

  always_comb begin
    mid.reject = (right < ext_e(tminx)) || (left > ext_e(tmaxx)) ||
                 (high < ext_e(tminy)) || (low > ext_e(tmaxy));
    mid.tri_in = |corner_in;
    for (int q = 0; q < 4; q++) begin
      for (int i = 0; i < 3; i++) begin
        mid.pa[q][i] = pa[q][i];
        mid.pb[q][i] = pb[q][i];
      end
    end
  end

endmodule

// ===== rtl/rto_decide.sv =====
// ----------------------------------------------------------------------------
// rto_decide
// Edge-test signs for each rectangle corner and the final verdict.
// ----------------------------------------------------------------------------
module rto_decide (
  input  rto_pkg::mid_t mid,
  output logic          hit,
  output logic [1:0]    decided_by
);
  import rto_pkg::*;

  logic signed [CrossBits-1:0] xprod [4][3];
  logic [3:0][2:0]             nonneg;
  logic [3:0]                  in_tri;

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      for (int i = 0; i < 3; i++) begin
        xprod[q][i]  = CrossBits'($signed(mid.pa[q][i])) -
                       CrossBits'($signed(mid.pb[q][i]));
        // zero counts as positive
        nonneg[q][i] = !xprod[q][i][CrossBits-1];
      end
      in_tri[q] = (&nonneg[q]) || !(|nonneg[q]);
    end
  end

  always_comb begin
    if (mid.reject) begin
      hit        = 1'b0;
      decided_by = DecReject;
    end else if (mid.tri_in) begin
      hit        = 1'b1;
      decided_by = DecTriInRect;
    end else if (|in_tri) begin
      hit        = 1'b1;
      decided_by = DecRectInTri;
    end else begin
      hit        = 1'b0;
      decided_by = DecNone;
    end
  end

endmodule

// ===== rtl/rect_triangle_overlap.sv =====
// ----------------------------------------------------------------------------
// rect_triangle_overlap
// Overlap test of an axis-aligned rectangle against a triangle.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one rectangle / triangle pair per transfer.
//   Master channel m_*: one verdict per pair, in order: hit flag and the
//   stage that decided (bounding reject, triangle corner in rectangle,
//   rectangle corner in triangle, no hit).
//   Pipeline: three register stages (input, products, result); a pair taken
//   at the input passes the product and result registers on to m_tvalid.
//   Throughput: one pair per cycle unless the receiver stalls. The product
//   stage holds two 17 x 18 multipliers per edge test, twelve tests at once.
//   Reset clears all valid flags; the data registers are not reset.
//   Receiver stall: each stage keeps its data while the next one is full
//   and stalled; s_tready falls only when all three stages hold a pair.
// ----------------------------------------------------------------------------
`include "rect_triangle_overlap_macros.svh"

module rect_triangle_overlap (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // rect_cx, rect_cy, rect_half_w, rect_half_h, tri_ax, tri_ay, tri_bx,
  // tri_by, tri_cx, tri_cy, zero fill
  input  logic [rto_pkg::InDataBits-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // hit, decided_by, zero fill
  output logic [rto_pkg::OutDataBits-1:0]    m_tdata
);
  import rto_pkg::*;

  logic       in_valid;
  in_item_t   in_item;
  logic       mid_valid;
  mid_t       mid;
  mid_t       mid_next;
  logic       hit;
  logic [1:0] decided_by;
  logic       hit_next;
  logic [1:0] decided_by_next;
  logic       out_ready;
  logic       mid_ready;
  logic       in_ready;

  assign out_ready = !m_tvalid || m_tready;
  assign mid_ready = !mid_valid || out_ready;
  assign in_ready  = !in_valid || mid_ready;
  assign s_tready  = in_ready;

  rto_setup u_setup (
    .item (in_item),
    .mid  (mid_next)
  );

  rto_decide u_decide (
    .mid        (mid),
    .hit        (hit_next),
    .decided_by (decided_by_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (in_ready) in_valid <= s_tvalid;
      if (mid_ready) mid_valid <= in_valid;
      if (out_ready) m_tvalid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && s_tvalid) in_item <= in_item_t'(s_tdata[InRawBits-1:0]);
    if (mid_ready && in_valid) mid <= mid_next;
    if (out_ready && mid_valid) begin
      hit        <= hit_next;
      decided_by <= decided_by_next;
    end
  end

  assign m_tdata = {(OutDataBits - OutRawBits)'(0), decided_by, hit};

  `RTO_ASSERT_NOW(a_hit_matches_code, m_tvalid,
    hit == ((decided_by == DecTriInRect) || (decided_by == DecRectInTri)),
    "hit flag disagrees with deciding stage")

  `RTO_ASSERT_NOW(a_full_pipe_blocks, in_valid && mid_valid && m_tvalid && !m_tready,
    !s_tready, "input taken while all stages are full")

  `RTO_ASSERT_NEXT(a_result_from_mid, !m_tvalid && !mid_valid, !m_tvalid,
    "result appeared without a pair in the product stage")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams rectangle / triangle pairs through rect_triangle_overlap and checks
// every verdict against a behavioral overlap predictor, in order. Both sides
// idle at random, and the receiver stalls long enough to back up the pipe.
// ----------------------------------------------------------------------------
module testbench;
  import rto_pkg::*;

  localparam int RandomPairs = 1880;

  typedef struct packed {
    logic [1:0] decided_by;
    logic       hit;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataBits-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataBits-1:0] m_tdata;

  in_item_t pairs_pending[$];
  verdict_t verdicts_due[$];
  in_item_t offered_pair = '0;
  logic offering;
  logic send_calm = 1'b0;
  logic recv_calm = 1'b0;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_left = 0;
  int results_seen = 0;
  int mismatches = 0;

  rect_triangle_overlap DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Overlap verdict: bounding box reject, triangle corner in rectangle,
  // rectangle corner in triangle, else no hit.
  function automatic verdict_t verdict_of(in_item_t p);
    longint tx[3];
    longint ty[3];
    longint qx[4];
    longint qy[4];
    longint ctr_x, ctr_y, hw, hh, left, right, low, high;
    longint mnx, mxx, mny, mxy, ex, ey, dx, dy;
    int pos;
    int j;
    ctr_x = $signed(p.rect_cx);
    ctr_y = $signed(p.rect_cy);
    hw = p.rect_half_w;
    hh = p.rect_half_h;
    tx[0] = $signed(p.tri_ax); ty[0] = $signed(p.tri_ay);
    tx[1] = $signed(p.tri_bx); ty[1] = $signed(p.tri_by);
    tx[2] = $signed(p.tri_cx); ty[2] = $signed(p.tri_cy);
    left = ctr_x - hw; right = ctr_x + hw;
    low = ctr_y - hh;  high = ctr_y + hh;
    mnx = tx[0]; mxx = tx[0]; mny = ty[0]; mxy = ty[0];
    for (int i = 1; i < 3; i++) begin
      if (tx[i] < mnx) mnx = tx[i];
      if (tx[i] > mxx) mxx = tx[i];
      if (ty[i] < mny) mny = ty[i];
      if (ty[i] > mxy) mxy = ty[i];
    end
    if (right < mnx || left > mxx || high < mny || low > mxy)
      return '{decided_by: DecReject, hit: 1'b0};
    for (int i = 0; i < 3; i++) begin
      if (left <= tx[i] && right >= tx[i] && low <= ty[i] && high >= ty[i])
        return '{decided_by: DecTriInRect, hit: 1'b1};
    end
    qx[0] = left;  qy[0] = low;
    qx[1] = left;  qy[1] = high;
    qx[2] = right; qy[2] = low;
    qx[3] = right; qy[3] = high;
    for (int k = 0; k < 4; k++) begin
      pos = 0;
      for (int i = 0; i < 3; i++) begin
        j = (i + 1) % 3;
        ex = tx[j] - tx[i]; ey = ty[j] - ty[i];
        dx = qx[k] - tx[i]; dy = qy[k] - ty[i];
        // zero cross product counts as the positive side
        if (ex * dy - ey * dx >= 0) pos++;
      end
      if (pos == 0 || pos == 3)
        return '{decided_by: DecRectInTri, hit: 1'b1};
    end
    return '{decided_by: DecNone, hit: 1'b0};
  endfunction

  function automatic in_item_t make_pair(int rcx, int rcy, int hw, int hh, int ax, int ay,
                                         int bx, int by, int ccx, int ccy);
    in_item_t p;
    p.rect_cx = 16'(rcx); p.rect_cy = 16'(rcy);
    p.rect_half_w = 15'(hw); p.rect_half_h = 15'(hh);
    p.tri_ax = 16'(ax); p.tri_ay = 16'(ay);
    p.tri_bx = 16'(bx); p.tri_by = 16'(by);
    p.tri_cx = 16'(ccx); p.tri_cy = 16'(ccy);
    return p;
  endfunction

  function automatic logic [15:0] around(logic [15:0] base, int spread);
    return base + 16'($urandom_range(0, 2 * spread) - spread);
  endfunction

  initial begin
    int spreads[4];
    int spread;
    logic [15:0] base_x, base_y;
    logic [159:0] raw;
    in_item_t p;
    spreads = '{8, 64, 2048, 30000};

    pairs_pending.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pairs_pending.push_back(make_pair(32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767, 32767, 32767));
    pairs_pending.push_back(make_pair(-32768, -32768, 0, 0,
                                      -32768, -32768, -32768, -32768, -32768, -32768));
    pairs_pending.push_back(make_pair(-32768, 0, 32767, 0,
                                      32767, 0, 32767, 5, 32767, -5));
    pairs_pending.push_back(make_pair(0, 0, 10, 10, 100, 100, 200, 100, 150, 200));
    // bounding boxes one apart, then touching
    pairs_pending.push_back(make_pair(0, 0, 10, 10, 11, -50, 11, 50, 30, 0));
    pairs_pending.push_back(make_pair(0, 0, 10, 10, 10, -50, 10, 50, 30, 0));
    pairs_pending.push_back(make_pair(0, 0, 10, 10, 10, 10, 50, 60, 70, 20));
    // enclosing triangle, both windings
    pairs_pending.push_back(make_pair(0, 0, 10, 10, -100, -100, 100, -100, 0, 100));
    pairs_pending.push_back(make_pair(0, 0, 10, 10, -100, -100, 0, 100, 100, -100));
    // thin triangle crosses the rectangle with no corner inside either
    pairs_pending.push_back(make_pair(0, 0, 10, 10, -100, 1, 100, 1, 100, 3));
    pairs_pending.push_back(make_pair(0, 0, 10, 10, 5, 20, 20, 5, 30, 30));
    // collinear corners: on the line counts as inside, off the line does not
    pairs_pending.push_back(make_pair(5, 5, 0, 0, 0, 0, 20, 20, 40, 40));
    pairs_pending.push_back(make_pair(10, 5, 2, 5, 0, 0, 40, 0, 20, 0));
    pairs_pending.push_back(make_pair(30, 10, 2, 2, 0, 0, 40, 40, 20, 20));
    pairs_pending.push_back(make_pair(32767, -32768, 32767, 32767,
                                      -32768, 32767, 32767, -32768, 0, 0));
    pairs_pending.push_back(make_pair(0, 0, 32767, 32767,
                                      -32768, -32768, 32767, -32768, -32768, 32767));
    pairs_pending.push_back(make_pair(0, 0, 32767, 0, -5, 3, 5, 3, 0, 9));
    pairs_pending.push_back(make_pair(16'h5555, 16'haaaa, 15'h2aaa, 15'h5555,
                                      16'haaaa, 16'h5555, 16'h5555, 16'h5555,
                                      16'haaaa, 16'haaaa));

    repeat (RandomPairs) begin
      if ($urandom_range(0, 4) == 0) begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        p = raw[$bits(in_item_t)-1:0];
      end else begin
        spread = spreads[$urandom_range(0, 3)];
        base_x = $urandom;
        base_y = $urandom;
        p.rect_cx = around(base_x, spread);
        p.rect_cy = around(base_y, spread);
        p.rect_half_w = 15'($urandom_range(0, spread));
        p.rect_half_h = 15'($urandom_range(0, spread));
        if ($urandom_range(0, 15) == 0) p.rect_half_w = '1;
        if ($urandom_range(0, 15) == 0) p.rect_half_h = '1;
        p.tri_ax = around(base_x, spread); p.tri_ay = around(base_y, spread);
        p.tri_bx = around(base_x, spread); p.tri_by = around(base_y, spread);
        p.tri_cx = around(base_x, spread); p.tri_cy = around(base_y, spread);
        // fold the triangle onto a segment now and then
        case ($urandom_range(0, 11))
          0: begin p.tri_cx = p.tri_ax; p.tri_cy = p.tri_ay; end
          1: begin p.tri_cx = p.tri_bx; p.tri_cy = p.tri_by; end
          2: begin p.tri_cy = p.tri_ay; p.tri_by = p.tri_ay; end
          default: ;
        endcase
      end
      pairs_pending.push_back(p);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (pairs_pending.size() != 0 || s_tvalid || verdicts_due.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Driver: offer the next pair after a drawn number of idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      offering = s_tvalid;
      if (s_tvalid && s_tready) begin
        verdicts_due.push_back(verdict_of(offered_pair));
        offering = 1'b0;
        if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, 9);
      end
      if (!offering) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pairs_pending.size() != 0) begin
          offered_pair = pairs_pending.pop_front();
          offering = 1'b1;
        end
      end
      s_tvalid <= offering;
      s_tdata <= InDataBits'(offered_pair);
    end
  end

  // Monitor: check each verdict transfer, then stall for a drawn number of cycles.
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, actual %0h", $time, m_tdata);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (m_tdata[0] !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b, actual %0b",
                     $time, want.hit, m_tdata[0]);
            mismatches++;
          end
          if (m_tdata[2:1] !== want.decided_by) begin
            $display("%0t: decided_by mismatch, expected %0d, actual %0d",
                     $time, want.decided_by, m_tdata[2:1]);
            mismatches++;
          end
        end
        results_seen++;
        if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 9);
        // hold off long enough for the pipe to fill and stall the input
        if (results_seen == 300 || results_seen == 1200) hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

endmodule
